// ----- rtl/svle_pkg.sv -----
// Shared types, constants and sizing functions for the stick vector level error unit.
package svle_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int IO_FRAC       = 14;
    localparam int MAX_ANGLE_RST = 65;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint DEG2RAD_Q30 = 64'sd18740330;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } op_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_FRAC,
        SH_30
    } sh_t;

    typedef enum logic [1:0] {
        U_IDLE,
        U_RUN,
        U_POST
    } ustate_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ANG_R1,
        ST_ANG_R2,
        ST_ANG_P1,
        ST_ANG_P2,
        ST_RED1,
        ST_RED2,
        ST_SQ,
        ST_DT,
        ST_MT,
        ST_MX,
        ST_SZ,
        ST_MAGX,
        ST_MAGY,
        ST_DEN,
        ST_RATIO,
        ST_ROOT,
        ST_SCX,
        ST_SCY,
        ST_REV,
        ST_E1,
        ST_E2,
        ST_E3,
        ST_E4,
        ST_FLIP,
        ST_OUT
    } state_t;

    // request from the sequencer to the serial arithmetic unit
    typedef struct packed {
        logic start;
        op_t  op;
        sh_t  sh;
        logic neg;
    } arith_req_t;

    // internal word: Q(F) with headroom for angles and scale factors
    function automatic int calc_w(input int f);
        return f + 10;
    endfunction

    // multiplier operand width: covers the internal word and the Q30 degree factor
    function automatic int calc_mw(input int f);
        return (f + 10 > 25) ? f + 10 : 25;
    endfunction

    // serial unit word: full product, divider dividend and root radicand
    function automatic int calc_uw(input int f);
        int a;
        a = 2 * calc_mw(f);
        if (3 * f + 2 > a) begin
            a = 3 * f + 2;
        end
        return a + (a % 2);
    endfunction

endpackage

// ----- rtl/svle_arith.sv -----
// Bit-serial arithmetic unit: shift-add multiply, restoring divide and integer square root.
module svle_arith #(
    parameter int FRAC_BITS = svle_pkg::FRAC_BITS_DEF,
    localparam int UW = svle_pkg::calc_uw(FRAC_BITS)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  svle_pkg::arith_req_t req,
    input  logic [UW-1:0]        ma,
    input  logic [UW-1:0]        mb,
    output logic                 done,
    output logic [UW-1:0]        res
);
    import svle_pkg::*;

    localparam int MW = calc_mw(FRAC_BITS);
    localparam int CW = $clog2(UW + 1);
    localparam logic [UW-1:0] HALF_F  = (UW'(1) << FRAC_BITS) >> 1;
    localparam logic [UW-1:0] HALF_30 = (UW'(1) << 30) >> 1;

    ustate_t         ust_reg, ust_next;
    op_t             op_reg, op_next;
    sh_t             sh_reg, sh_next;
    logic            neg_reg, neg_next;
    logic [UW-1:0]   a_reg, a_next;
    logic [UW-1:0]   b_reg, b_next;
    logic [UW+1:0]   acc_reg, acc_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [UW-1:0]   res_reg, res_next;

    logic [UW:0]     r2;
    logic [UW+1:0]   r3;
    logic [UW+1:0]   trial;
    logic            geq;
    logic [UW-1:0]   p;
    logic [UW-1:0]   m;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ust_reg  <= U_IDLE;
            done_reg <= 1'b0;
        end else begin
            ust_reg  <= ust_next;
            done_reg <= done_next;
        end
        op_reg  <= op_next;
        sh_reg  <= sh_next;
        neg_reg <= neg_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    always_comb begin
        ust_next  = ust_reg;
        op_next   = op_reg;
        sh_next   = sh_reg;
        neg_next  = neg_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        r2        = '0;
        r3        = '0;
        trial     = '0;
        geq       = 1'b0;
        p         = acc_reg[UW-1:0];
        m         = '0;
        unique case (ust_reg)
            U_IDLE: begin
                if (req.start) begin
                    op_next  = req.op;
                    sh_next  = req.sh;
                    neg_next = req.neg;
                    a_next   = ma;
                    b_next   = (req.op == OP_SQRT) ? '0 : mb;
                    acc_next = '0;
                    case (req.op)
                        OP_MUL:  cnt_next = CW'(MW);
                        OP_DIV:  cnt_next = CW'(UW);
                        default: cnt_next = CW'(UW / 2);
                    endcase
                    ust_next = U_RUN;
                end
            end
            U_RUN: begin
                case (op_reg)
                    OP_MUL: begin
                        if (b_reg[0]) begin
                            acc_next = acc_reg + {2'b00, a_reg};
                        end
                        a_next = a_reg << 1;
                        b_next = b_reg >> 1;
                    end
                    OP_DIV: begin
                        // quotient bits shift into a_reg as dividend bits leave
                        r2 = {acc_reg[UW-1:0], a_reg[UW-1]};
                        geq = (r2 >= {1'b0, b_reg});
                        acc_next = geq ? {1'b0, r2 - {1'b0, b_reg}} : {1'b0, r2};
                        a_next = {a_reg[UW-2:0], geq};
                    end
                    default: begin
                        // two radicand bits per step, root builds in b_reg
                        r3 = {acc_reg[UW-1:0], a_reg[UW-1:UW-2]};
                        trial = {b_reg, 2'b01};
                        geq = (r3 >= trial);
                        acc_next = geq ? r3 - trial : r3;
                        b_next = {b_reg[UW-2:0], geq};
                        a_next = a_reg << 2;
                    end
                endcase
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    ust_next = U_POST;
                end
            end
            U_POST: begin
                case (op_reg)
                    OP_MUL: begin
                        case (sh_reg)
                            SH_NONE: m = p;
                            SH_FRAC: m = (p + HALF_F) >> FRAC_BITS;
                            default: m = (p + HALF_30) >> 30;
                        endcase
                    end
                    OP_DIV:  m = a_reg;
                    default: m = b_reg;
                endcase
                res_next  = neg_reg ? (~m + 1'b1) : m;
                done_next = 1'b1;
                ust_next  = U_IDLE;
            end
            default: ust_next = U_IDLE;
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ----- rtl/stick_vector_level_error_unit.sv -----
// Top level: stick to target vector, cross-product level error and flip recovery.
// Each word takes up to 34 multiplies, 17 divides and one square root, all through the
// single shared bit-serial unit (MW 25, UW 50 at FRAC_BITS 14).
// Throughput: one word at a time; the next word is taken once the previous has reached
// the output register. Reset (aresetn low, synchronous) clears the sequencer, the output
// valid, the flip latch and restores max_angle_deg to 65 and inverted_enable to 0.
module stick_vector_level_error_unit #(
    parameter int FRAC_BITS = svle_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // stick_roll, stick_pitch, grav_x, grav_y, grav_z
    input  logic [1:0]  s_tuser,   // inverted_switch, motors_reversed
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // error_roll, error_pitch
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata
);
    import svle_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int W  = calc_w(F);
    localparam int UW = calc_uw(F);

    localparam int CFG_MAX_ANGLE = 0;
    localparam int CFG_INV_EN    = 1;

    // input and output format conversion
    localparam int SHL  = (F >= IO_FRAC) ? F - IO_FRAC : 0;
    localparam int SHR  = (F <  IO_FRAC) ? IO_FRAC - F : 0;
    localparam logic [W-1:0] HALF_IN  = W'((64'd1 << SHR) >> 1);
    localparam logic [W-1:0] HALF_OUT = W'((64'd1 << SHL) >> 1);

    // Q(F) constants
    localparam longint ONE_L  = longint'(1) << F;
    localparam longint RH_L   = (longint'(1) << (30 - F)) >> 1;
    localparam longint PI_L   = (PI_Q30 + RH_L) >> (30 - F);
    localparam longint HP_L   = (PI_Q30 / 2 + RH_L) >> (30 - F);
    localparam longint THR_L  = (ONE_L + 500) / 1000;
    localparam longint C707_L = (707 * ONE_L + 500) / 1000;

    localparam logic signed [W-1:0] ONE    = W'(ONE_L);
    localparam logic signed [W:0]   ONE_X  = (W+1)'(ONE_L);
    localparam logic signed [W-1:0] PI_W   = W'(PI_L);
    localparam logic signed [W-1:0] TWO_PI = W'(2 * PI_L);
    localparam logic signed [W-1:0] HP_W   = W'(HP_L);
    localparam logic signed [W-1:0] THR    = W'(THR_L);
    localparam logic signed [W-1:0] C707   = W'(C707_L);
    localparam logic signed [W-1:0] GT     = W'(ONE_L >> 3);
    localparam logic signed [W-1:0] QTR    = W'(ONE_L >> 2);
    localparam logic [UW-1:0]       DEG_U  = UW'(DEG2RAD_Q30);

    function automatic logic signed [W-1:0] from_io(input logic [15:0] raw);
        logic signed [W-1:0] x;
        logic [W-1:0]        u;
        x = W'(signed'(raw));
        u = x[W-1] ? W'(-x) : W'(x);
        u = (u + HALF_IN) >> SHR;
        if (F >= IO_FRAC) begin
            return x <<< SHL;
        end
        return x[W-1] ? -signed'(u) : signed'(u);
    endfunction

    function automatic logic [15:0] to_io(input logic signed [W-1:0] v);
        logic [W-1:0]        u;
        logic signed [W-1:0] x;
        u = v[W-1] ? W'(-v) : W'(v);
        u = (u + HALF_OUT) >> SHL;
        x = v[W-1] ? -signed'(u) : signed'(u);
        if (F >= IO_FRAC) begin
            return x[15:0];
        end
        x = v <<< SHR;
        return x[15:0];
    endfunction

    function automatic logic [UW-1:0] mag(input logic signed [W-1:0] v);
        logic [W-1:0] u;
        u = v[W-1] ? W'(-v) : W'(v);
        return UW'(u);
    endfunction

    function automatic logic signed [W-1:0] clamp1(input logic signed [W:0] v);
        if (v > ONE_X) begin
            return ONE;
        end
        if (v < -ONE_X) begin
            return -ONE;
        end
        return v[W-1:0];
    endfunction

    // series divisors, highest term first
    function automatic logic [UW-1:0] series_div(input logic [1:0] j);
        case (j)
            2'd0:    return UW'(72);
            2'd1:    return UW'(42);
            2'd2:    return UW'(20);
            default: return UW'(6);
        endcase
    endfunction

    // sequencer and configuration
    state_t              state_reg, state_next;
    logic                run_reg, run_next;
    logic [6:0]          max_reg, max_next;
    logic                en_reg, en_next;

    // captured word
    logic signed [W-1:0] sr_reg, sr_next;
    logic signed [W-1:0] sp_reg, sp_next;
    logic signed [W-1:0] gx_reg, gx_next;
    logic signed [W-1:0] gy_reg, gy_next;
    logic signed [W-1:0] gz_reg, gz_next;
    logic                sw_reg, sw_next;
    logic                mr_reg, mr_next;

    // working values
    logic signed [W-1:0] ar_reg, ar_next;
    logic signed [W-1:0] ap_reg, ap_next;
    logic signed [W-1:0] sx_reg, sx_next;
    logic signed [W-1:0] sy_reg, sy_next;
    logic signed [W-1:0] cr_reg, cr_next;
    logic signed [W-1:0] cp_reg, cp_next;
    logic signed [W-1:0] sz_reg, sz_next;
    logic signed [W-1:0] x_reg, x_next;
    logic signed [W-1:0] x2_reg, x2_next;
    logic signed [W-1:0] t_reg, t_next;
    logic signed [W-1:0] tmp_reg, tmp_next;
    logic signed [W-1:0] mag2_reg, mag2_next;
    logic signed [W-1:0] den_reg, den_next;
    logic signed [W-1:0] scale_reg, scale_next;
    logic [UW-1:0]       ratio_reg, ratio_next;
    logic [1:0]          k_reg, k_next;
    logic [1:0]          j_reg, j_next;
    logic signed [W-1:0] er_reg, er_next;
    logic signed [W-1:0] ep_reg, ep_next;

    // flip recovery state
    logic                latched_reg, latched_next;
    logic                axis_reg, axis_next;
    logic                dir_reg, dir_next;

    // output register
    logic                mv_reg, mv_next;
    logic [31:0]         md_reg, md_next;

    // serial unit
    arith_req_t          req;
    logic [UW-1:0]       ma, mb;
    logic                u_done;
    logic [UW-1:0]       u_res;
    logic signed [W-1:0] rw;

    // combinational temporaries
    logic                arith;
    logic signed [W-1:0] arg, xr, gsel, gother, sum;
    logic signed [W:0]   diff;
    logic                active;

    svle_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .ma      (ma),
        .mb      (mb),
        .done    (u_done),
        .res     (u_res)
    );

    assign rw = signed'(u_res[W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            run_reg     <= 1'b0;
            max_reg     <= 7'(MAX_ANGLE_RST);
            en_reg      <= 1'b0;
            latched_reg <= 1'b0;
            axis_reg    <= 1'b0;
            dir_reg     <= 1'b0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            run_reg     <= run_next;
            max_reg     <= max_next;
            en_reg      <= en_next;
            latched_reg <= latched_next;
            axis_reg    <= axis_next;
            dir_reg     <= dir_next;
            mv_reg      <= mv_next;
        end
        sr_reg    <= sr_next;
        sp_reg    <= sp_next;
        gx_reg    <= gx_next;
        gy_reg    <= gy_next;
        gz_reg    <= gz_next;
        sw_reg    <= sw_next;
        mr_reg    <= mr_next;
        ar_reg    <= ar_next;
        ap_reg    <= ap_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        cr_reg    <= cr_next;
        cp_reg    <= cp_next;
        sz_reg    <= sz_next;
        x_reg     <= x_next;
        x2_reg    <= x2_next;
        t_reg     <= t_next;
        tmp_reg   <= tmp_next;
        mag2_reg  <= mag2_next;
        den_reg   <= den_next;
        scale_reg <= scale_next;
        ratio_reg <= ratio_next;
        k_reg     <= k_next;
        j_reg     <= j_next;
        er_reg    <= er_next;
        ep_reg    <= ep_next;
        md_reg    <= md_next;
    end

    always_comb begin
        state_next   = state_reg;
        run_next     = run_reg;
        max_next     = max_reg;
        en_next      = en_reg;
        sr_next      = sr_reg;
        sp_next      = sp_reg;
        gx_next      = gx_reg;
        gy_next      = gy_reg;
        gz_next      = gz_reg;
        sw_next      = sw_reg;
        mr_next      = mr_reg;
        ar_next      = ar_reg;
        ap_next      = ap_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        cr_next      = cr_reg;
        cp_next      = cp_reg;
        sz_next      = sz_reg;
        x_next       = x_reg;
        x2_next      = x2_reg;
        t_next       = t_reg;
        tmp_next     = tmp_reg;
        mag2_next    = mag2_reg;
        den_next     = den_reg;
        scale_next   = scale_reg;
        ratio_next   = ratio_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        er_next      = er_reg;
        ep_next      = ep_reg;
        latched_next = latched_reg;
        axis_next    = axis_reg;
        dir_next     = dir_reg;
        mv_next      = mv_reg && !m_tready;
        md_next      = md_reg;
        s_tready     = 1'b0;
        req.op       = OP_MUL;
        req.sh       = SH_FRAC;
        req.neg      = 1'b0;
        ma           = '0;
        mb           = '0;
        arith        = 1'b0;
        arg          = '0;
        xr           = '0;
        gsel         = '0;
        gother       = '0;
        sum          = '0;
        diff         = '0;
        active       = 1'b0;

        if (cfg_wr_en) begin
            case (cfg_index)
                1'(CFG_MAX_ANGLE): max_next = cfg_wdata;
                1'(CFG_INV_EN):    en_next  = cfg_wdata[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    sr_next    = from_io(s_tdata[15:0]);
                    sp_next    = from_io(s_tdata[31:16]);
                    gx_next    = from_io(s_tdata[47:32]);
                    gy_next    = from_io(s_tdata[63:48]);
                    gz_next    = from_io(s_tdata[79:64]);
                    sw_next    = s_tuser[0];
                    mr_next    = s_tuser[1];
                    state_next = ST_ANG_R1;
                end
            end
            // stick times full-scale degrees, exact
            ST_ANG_R1, ST_ANG_P1: begin
                arith   = 1'b1;
                req.op  = OP_MUL;
                req.sh  = SH_NONE;
                if (state_reg == ST_ANG_R1) begin
                    ma      = mag(sr_reg);
                    req.neg = sr_reg[W-1];
                end else begin
                    ma      = mag(sp_reg);
                    req.neg = sp_reg[W-1];
                end
                mb = UW'(max_reg);
                if (u_done) begin
                    tmp_next   = rw;
                    state_next = (state_reg == ST_ANG_R1) ? ST_ANG_R2 : ST_ANG_P2;
                end
            end
            // degrees to radians by the Q30 factor, result in Q(F)
            ST_ANG_R2, ST_ANG_P2: begin
                arith   = 1'b1;
                req.op  = OP_MUL;
                req.sh  = SH_30;
                ma      = mag(tmp_reg);
                mb      = DEG_U;
                req.neg = tmp_reg[W-1];
                if (u_done) begin
                    if (state_reg == ST_ANG_R2) begin
                        ar_next    = rw;
                        state_next = ST_ANG_P1;
                    end else begin
                        ap_next    = rw;
                        k_next     = 2'd0;
                        state_next = ST_RED1;
                    end
                end
            end
            // k: sin roll, sin pitch, cos roll, cos pitch
            ST_RED1: begin
                arg = k_reg[0] ? ap_reg : ar_reg;
                if (k_reg[1]) begin
                    arg = arg + HP_W;
                end
                if (arg > PI_W) begin
                    arg = arg - TWO_PI;
                end
                if (arg < -PI_W) begin
                    arg = arg + TWO_PI;
                end
                x_next     = arg;
                state_next = ST_RED2;
            end
            // fold into [-pi/2, pi/2]
            ST_RED2: begin
                xr = x_reg;
                if (xr > HP_W) begin
                    xr = PI_W - xr;
                end
                if (xr < -HP_W) begin
                    xr = -PI_W - xr;
                end
                x_next     = xr;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                arith  = 1'b1;
                req.op = OP_MUL;
                ma     = mag(x_reg);
                mb     = mag(x_reg);
                if (u_done) begin
                    x2_next    = rw;
                    j_next     = 2'd0;
                    state_next = ST_DT;
                end
            end
            // Horner term: t = 1 - (x2 * t) / d
            ST_DT: begin
                arith  = 1'b1;
                req.op = OP_DIV;
                if (j_reg == 2'd0) begin
                    ma      = mag(x2_reg);
                    req.neg = x2_reg[W-1];
                end else begin
                    ma      = mag(tmp_reg);
                    req.neg = tmp_reg[W-1];
                end
                mb = series_div(j_reg);
                if (u_done) begin
                    t_next     = ONE - rw;
                    j_next     = j_reg + 2'd1;
                    state_next = (j_reg == 2'd3) ? ST_MX : ST_MT;
                end
            end
            ST_MT: begin
                arith   = 1'b1;
                req.op  = OP_MUL;
                ma      = mag(x2_reg);
                mb      = mag(t_reg);
                req.neg = x2_reg[W-1] ^ t_reg[W-1];
                if (u_done) begin
                    tmp_next   = rw;
                    state_next = ST_DT;
                end
            end
            ST_MX: begin
                arith   = 1'b1;
                req.op  = OP_MUL;
                ma      = mag(x_reg);
                mb      = mag(t_reg);
                req.neg = x_reg[W-1] ^ t_reg[W-1];
                if (u_done) begin
                    case (k_reg)
                        2'd0:    sx_next = clamp1((W+1)'(rw));
                        2'd1:    sy_next = clamp1((W+1)'(rw));
                        2'd2:    cr_next = clamp1((W+1)'(rw));
                        default: cp_next = clamp1((W+1)'(rw));
                    endcase
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? ST_SZ : ST_RED1;
                end
            end
            ST_SZ: begin
                arith   = 1'b1;
                req.op  = OP_MUL;
                ma      = mag(cr_reg);
                mb      = mag(cp_reg);
                req.neg = cr_reg[W-1] ^ cp_reg[W-1];
                if (u_done) begin
                    sz_next    = rw;
                    state_next = ST_MAGX;
                end
            end
            ST_MAGX: begin
                arith  = 1'b1;
                req.op = OP_MUL;
                ma     = mag(sx_reg);
                mb     = mag(sx_reg);
                if (u_done) begin
                    tmp_next   = rw;
                    state_next = ST_MAGY;
                end
            end
            // at or below the threshold the fixed 0.707 scale applies
            ST_MAGY: begin
                arith  = 1'b1;
                req.op = OP_MUL;
                ma     = mag(sy_reg);
                mb     = mag(sy_reg);
                if (u_done) begin
                    sum       = tmp_reg + rw;
                    mag2_next = sum;
                    if (sum > THR) begin
                        state_next = ST_DEN;
                    end else begin
                        scale_next = C707;
                        state_next = ST_SCX;
                    end
                end
            end
            ST_DEN: begin
                arith  = 1'b1;
                req.op = OP_MUL;
                ma     = mag(sz_reg);
                mb     = mag(sz_reg);
                if (u_done) begin
                    sum        = ONE - rw;
                    den_next   = sum[W-1] ? '0 : sum;
                    state_next = ST_RATIO;
                end
            end
            ST_RATIO: begin
                arith  = 1'b1;
                req.op = OP_DIV;
                ma     = UW'(unsigned'(den_reg)) << F;
                mb     = UW'(unsigned'(mag2_reg));
                if (u_done) begin
                    ratio_next = u_res;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                arith  = 1'b1;
                req.op = OP_SQRT;
                ma     = ratio_reg << F;
                if (u_done) begin
                    scale_next = rw;
                    state_next = ST_SCX;
                end
            end
            ST_SCX: begin
                arith   = 1'b1;
                req.op  = OP_MUL;
                ma      = mag(sx_reg);
                mb      = mag(scale_reg);
                req.neg = sx_reg[W-1];
                if (u_done) begin
                    sx_next    = rw;
                    state_next = ST_SCY;
                end
            end
            ST_SCY: begin
                arith   = 1'b1;
                req.op  = OP_MUL;
                ma      = mag(sy_reg);
                mb      = mag(scale_reg);
                req.neg = sy_reg[W-1];
                if (u_done) begin
                    sy_next    = rw;
                    state_next = ST_REV;
                end
            end
            ST_REV: begin
                if (en_reg && mr_reg) begin
                    sx_next = -sx_reg;
                    sy_next = -sy_reg;
                    sz_next = -sz_reg;
                end
                state_next = ST_E1;
            end
            ST_E1: begin
                arith   = 1'b1;
                req.op  = OP_MUL;
                ma      = mag(gy_reg);
                mb      = mag(sz_reg);
                req.neg = gy_reg[W-1] ^ sz_reg[W-1];
                if (u_done) begin
                    tmp_next   = rw;
                    state_next = ST_E2;
                end
            end
            ST_E2: begin
                arith   = 1'b1;
                req.op  = OP_MUL;
                ma      = mag(gz_reg);
                mb      = mag(sy_reg);
                req.neg = gz_reg[W-1] ^ sy_reg[W-1];
                if (u_done) begin
                    diff       = (W+1)'(tmp_reg) - (W+1)'(rw);
                    ep_next    = clamp1(-diff);
                    state_next = ST_E3;
                end
            end
            ST_E3: begin
                arith   = 1'b1;
                req.op  = OP_MUL;
                ma      = mag(gz_reg);
                mb      = mag(sx_reg);
                req.neg = gz_reg[W-1] ^ sx_reg[W-1];
                if (u_done) begin
                    tmp_next   = rw;
                    state_next = ST_E4;
                end
            end
            ST_E4: begin
                arith   = 1'b1;
                req.op  = OP_MUL;
                ma      = mag(gx_reg);
                mb      = mag(sz_reg);
                req.neg = gx_reg[W-1] ^ sz_reg[W-1];
                if (u_done) begin
                    diff       = (W+1)'(tmp_reg) - (W+1)'(rw);
                    er_next    = clamp1(diff);
                    state_next = ST_FLIP;
                end
            end
            // forced error on the latched axis first, then latch, then the other axis
            ST_FLIP: begin
                if (en_reg) begin
                    if (sw_reg && (gz_reg > GT)) begin
                        active = 1'b1;
                        if (axis_reg) ep_next = dir_reg ? ONE : -ONE;
                        else          er_next = dir_reg ? ONE : -ONE;
                    end else if (!sw_reg && (gz_reg < -GT)) begin
                        active = 1'b1;
                        if (axis_reg) ep_next = dir_reg ? -ONE : ONE;
                        else          er_next = dir_reg ? -ONE : ONE;
                    end else begin
                        latched_next = 1'b0;
                    end
                    if (active) begin
                        if (!latched_reg) begin
                            gsel = gx_reg[W-1] ? -gx_reg : gx_reg;
                            xr   = gy_reg[W-1] ? -gy_reg : gy_reg;
                            axis_next    = !((gsel + QTR) > xr);
                            arg          = axis_next ? gy_reg : gx_reg;
                            dir_next     = !arg[W-1] && (arg != '0);
                            latched_next = 1'b1;
                        end
                        gother = axis_next ? gx_reg : gy_reg;
                        if (axis_next) er_next = clamp1((W+1)'(gother));
                        else           ep_next = clamp1((W+1)'(gother));
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {to_io(ep_reg), to_io(er_reg)};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // one request per arithmetic step, cleared when the unit answers
        req.start = arith && !run_reg;
        if (req.start) begin
            run_next = 1'b1;
        end
        if (u_done) begin
            run_next = 1'b0;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

endmodule

// ----- rtl/svle_checker.sv -----
// Port-level checker for the stick vector level error unit, bound to the top level.
module svle_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result word stays
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed while stalled");

    // one word in work: no accept directly after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in work");

    // both errors clamped to plus or minus one
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384)
                  && ($signed(m_tdata[15:0]) >= -16'sd16384)
                  && ($signed(m_tdata[31:16]) <= 16'sd16384)
                  && ($signed(m_tdata[31:16]) >= -16'sd16384))
        else $error("error word out of range");

    // reset empties the output register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind stick_vector_level_error_unit svle_props u_svle_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
